/* rtl/ppt_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the pick-and-place torque profile
// no dependencies
package ppt_pkg;

  localparam int TIME_FRAC_BITS = 20;
  localparam int IN_W   = 24;
  localparam int TQ_W   = 25;
  localparam int U_W    = TIME_FRAC_BITS + 1;
  localparam int X_W    = 31;
  localparam int Q30    = 30;
  localparam int LOC_W  = 33;
  localparam int ADDR_W = 3;

  localparam int unsigned REG_WINDOW_LOW  = 0;
  localparam int unsigned REG_WINDOW_HIGH = 1;

  localparam logic [IN_W-1:0] WINDOW_LOW_RST  = 24'd311231;
  localparam logic [IN_W-1:0] WINDOW_HIGH_RST = 24'd311369;

  // polynomial factor 5255 + 13439u - 18694u^2
  localparam logic [45:0] FAC_C0 = 46'd5255 << Q30;
  localparam logic [14:0] FAC_C1 = 15'd13439;
  localparam logic [14:0] FAC_C2 = 15'd18694;

  // torque = round(f * K_NUM / 8e9), with 8e9 = 2^12 * DIV_D
  localparam logic [25:0] K_NUM    = 26'd47523465;
  localparam logic [31:0] K_HALF   = 32'd4000000000;
  localparam logic [20:0] DIV_D    = 21'd1953125;
  localparam logic [27:0] DIV_R    = 28'd144115188;
  localparam logic [27:0] TQ_MAXP  = 28'd16777215;
  localparam logic [27:0] TQ_MAXN  = 28'd16777216;

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_PICK   = 2'd1,
    PH_PLACE  = 2'd2,
    PH_RETURN = 2'd3
  } phase_e;

  typedef struct packed {
    logic [U_W-1:0] u;
    logic           neg;
    phase_e         phase;
  } item_t;

  typedef struct packed {
    logic   neg;
    phase_e phase;
  } meta_t;

endpackage

/* rtl/ppt_front.sv */
`timescale 1ns / 1ps
// front end: takes input transfers, tests detection, picks phase and local time
// depends on ppt_pkg
module ppt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [23:0] time_now, [47:24] object_distance, [71:48] goal_distance
  input  logic [71:0]              s_axis_tdata,
  input  logic [ppt_pkg::IN_W-1:0] window_low_i,
  input  logic [ppt_pkg::IN_W-1:0] window_high_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output ppt_pkg::item_t           push_item_o
);
  import ppt_pkg::*;

  localparam logic [LOC_W-1:0] T1 = LOC_W'(1) << TIME_FRAC_BITS;

  logic [IN_W-1:0]  t, od, gd;
  logic             od_det, gd_det;
  logic [LOC_W-1:0] t_w, loc;
  logic [1:0]       seg;
  logic [TIME_FRAC_BITS-1:0] frac;
  logic [U_W-1:0]   u_rev;
  item_t            cls;
  item_t            item_q;
  logic             fv_q, fv_d;

  assign t  = s_axis_tdata[23:0];
  assign od = s_axis_tdata[47:24];
  assign gd = s_axis_tdata[71:48];
  assign od_det = (od > window_low_i) && (od < window_high_i);
  assign gd_det = (gd > window_low_i) && (gd < window_high_i);
  assign t_w = LOC_W'(t);

  always_comb begin
    cls.phase = PH_NONE;
    loc = '0;
    if (t_w < 2 * T1 && od_det) begin
      cls.phase = PH_PICK;
      loc = t_w;
    end else if (t_w >= 2 * T1 && t_w < 6 * T1 && gd_det) begin
      cls.phase = PH_PLACE;
      loc = t_w - 2 * T1;
    end else if (t_w >= 6 * T1 && t_w < 8 * T1) begin
      cls.phase = PH_RETURN;
      loc = t_w - 6 * T1;
    end
    seg  = 2'(loc >> TIME_FRAC_BITS);
    frac = loc[TIME_FRAC_BITS-1:0];
    u_rev = U_W'(T1) - U_W'(frac);
    cls.u = seg[0] ? u_rev : U_W'(frac);
    case (cls.phase)
      PH_PICK, PH_RETURN: cls.neg = ~seg[0];
      PH_PLACE:           cls.neg = seg[0];
      default:            cls.neg = 1'b0;
    endcase
  end

  assign s_axis_tready = ~fv_q | push_ready_i;

  always_comb begin
    fv_d = fv_q;
    if (s_axis_tvalid && s_axis_tready) begin
      fv_d = 1'b1;
    end else if (push_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= cls;
    end
  end

  assign push_valid_o = fv_q;
  assign push_item_o  = item_q;

endmodule

/* rtl/ppt_queue.sv */
`timescale 1ns / 1ps
// two-entry queue between front end and arithmetic pipeline
// depends on ppt_pkg
module ppt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ppt_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output ppt_pkg::item_t pop_item_o
);
  import ppt_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_q];
  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/ppt_back.sv */
`timescale 1ns / 1ps
// back end: ten-stage polynomial, scaling and saturation pipeline
// depends on ppt_pkg
module ppt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_o,
  input  ppt_pkg::item_t pop_item_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // [24:0] torque, [31:25] zero
  output logic [31:0]    m_axis_tdata,
  // [1:0] phase
  output logic [1:0]     m_axis_tuser
);
  import ppt_pkg::*;

  localparam int NSTG = 10;

  logic [NSTG-1:0] v_q;
  meta_t           meta_q [NSTG];
  logic            en;

  logic [X_W-1:0]  x_in;
  logic [61:0]     p1, p2, p3, p4;
  logic [59:0]     p5, p6;
  logic [45:0]     fac;
  logic [51:0]     p7h, p7l;
  logic [75:0]     s8;
  logic [48:0]     p9, r9;
  logic [27:0]     q9, mag;

  logic [X_W-1:0]  x1_q, x2_q, x2b_q, x4_q, x3_q, x8_q, x9_q;
  logic [28:0]     f2_q, f3_q, f4_q;
  logic [32:0]     f_q;
  logic [47:0]     pp6_q, pp7_q, pp8_q;
  logic [51:0]     h7_q, l7_q;
  logic [27:0]     qe8_q, q9_q;
  logic [TQ_W-1:0] tq_q;

  assign en    = ~v_q[NSTG-1] | m_axis_tready;
  assign pop_o = en & pop_valid_i;

  assign x_in = X_W'(pop_item_i.u) << (Q30 - TIME_FRAC_BITS);
  assign p1   = 62'(x_in) * 62'(x_in);
  assign p2   = 62'(x2_q) * 62'(x2_q);
  assign fac  = FAC_C0 + 46'(FAC_C1) * 46'(x1_q) - 46'(FAC_C2) * 46'(x2_q);
  assign p3   = 62'(x4_q) * 62'(x4_q);
  assign p4   = 62'(x8_q) * 62'(x3_q);
  assign p5   = 60'(x9_q) * 60'(f4_q);
  assign p6   = 60'(f_q) * 60'(K_NUM) + 60'(K_HALF);
  assign p7h  = 52'(pp6_q[47:24]) * 52'(DIV_R);
  assign p7l  = 52'(pp6_q[23:0]) * 52'(DIV_R);
  assign s8   = {h7_q, 24'd0} + 76'(l7_q);
  assign p9   = 49'(qe8_q) * 49'(DIV_D);
  assign r9   = 49'(pp8_q) - p9;
  assign q9   = (r9 >= 49'(DIV_D)) ? qe8_q + 28'd1 : qe8_q;

  always_comb begin
    if (meta_q[8].neg) begin
      mag = (q9_q > TQ_MAXN) ? TQ_MAXN : q9_q;
    end else begin
      mag = (q9_q > TQ_MAXP) ? TQ_MAXP : q9_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], pop_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= '{neg: pop_item_i.neg, phase: pop_item_i.phase};
      for (int i = 1; i < NSTG; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      // x^2
      x1_q  <= x_in;
      x2_q  <= p1[60:30];
      // x^4 and factor
      x2b_q <= x1_q;
      x4_q  <= p2[60:30];
      f2_q  <= fac[42:14];
      // x^8
      x3_q  <= x2b_q;
      x8_q  <= p3[60:30];
      f3_q  <= f2_q;
      // x^9
      x9_q  <= p4[60:30];
      f4_q  <= f3_q;
      // f in q20
      f_q   <= p5[58:26];
      // scaled and rounded, pre-shifted by 2^12
      pp6_q <= p6[59:12];
      // reciprocal partial products
      h7_q  <= p7h;
      l7_q  <= p7l;
      pp7_q <= pp6_q;
      pp8_q <= pp7_q;
      qe8_q <= s8[75:48];
      q9_q  <= q9;
      tq_q  <= meta_q[8].neg ? TQ_W'(~mag + 28'd1) : TQ_W'(mag);
    end
  end

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {7'd0, tq_q};
  assign m_axis_tuser  = meta_q[NSTG-1].phase;

endmodule

/* rtl/pick_place_torque_profile.sv */
`timescale 1ns / 1ps
// Torque profile generator for a pick-and-place arm: one result per input
// transfer, sustained at one transfer per clock while m_axis_tready is high. A
// transfer passes a front register, a two-entry queue and a ten-stage
// arithmetic pipeline (the chain of multipliers for u^9, the factor, the scale
// and the reciprocal division), in that order; the pipeline advances whenever
// its output register is empty or being read.
// Detection window bounds are set over the APB port at byte addresses 0 and 4.
// depends on ppt_pkg, ppt_front, ppt_queue, ppt_back
module pick_place_torque_profile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppt_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [23:0] time_now, [47:24] object_distance, [71:48] goal_distance
  input  logic [71:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [24:0] torque, [31:25] zero
  output logic [31:0]                 m_axis_tdata,
  // [1:0] phase
  output logic [1:0]                  m_axis_tuser
);
  import ppt_pkg::*;

  logic [IN_W-1:0] win_lo_q, win_hi_q;
  logic            wr_en;
  logic            push_valid, push_ready, pop_valid, pop;
  item_t           push_item, pop_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (32'(paddr[2]) == REG_WINDOW_HIGH) ? 32'(win_hi_q) : 32'(win_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= WINDOW_LOW_RST;
      win_hi_q <= WINDOW_HIGH_RST;
    end else if (wr_en) begin
      if (32'(paddr[2]) == REG_WINDOW_LOW) begin
        win_lo_q <= pwdata[IN_W-1:0];
      end else begin
        win_hi_q <= pwdata[IN_W-1:0];
      end
    end
  end

  ppt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .window_low_i  (win_lo_q),
    .window_high_i (win_hi_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  ppt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  ppt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_item_i    (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* verif/tb_pick_place_torque_profile.sv */
`timescale 1ns / 1ps
// self-checking testbench of pick_place_torque_profile: stream stimulus with idle and stall phases,
// apb window writes between phases, torque and phase predicted per transfer and compared in order
// depends on ppt_pkg and the pick_place_torque_profile rtl
module tb_pick_place_torque_profile;
  import ppt_pkg::*;

  localparam longint T1 = longint'(1) << TIME_FRAC_BITS;

  class torque_board;
    logic [24:0] exp_torque[$];
    phase_e      exp_phase[$];
    logic [23:0] win_lo = WINDOW_LOW_RST;
    logic [23:0] win_hi = WINDOW_HIGH_RST;
    int          errors = 0;

    function longint poly(longint u);
      longint x, x2, x4, x8, x9, fac;
      x   = u << (30 - TIME_FRAC_BITS);
      x2  = (x * x) >>> 30;
      x4  = (x2 * x2) >>> 30;
      x8  = (x4 * x4) >>> 30;
      x9  = (x8 * x) >>> 30;
      fac = ((longint'(5255) << 30) + 13439 * x - 18694 * x2) >>> 14;
      return (x9 * fac) >>> 26;
    endfunction

    function longint pick_sum(longint x);
      longint a;
      a = 0;
      if (x <= T1) a -= poly(x);
      if (x >= T1 && x <= 2 * T1) a += poly(2 * T1 - x);
      return a;
    endfunction

    function longint place_sum(longint s);
      longint a;
      a = 0;
      if (s <= T1) a += poly(s);
      if (s >= T1 && s <= 2 * T1) a -= poly(2 * T1 - s);
      if (s >= 2 * T1 && s <= 3 * T1) a += poly(s - 2 * T1);
      if (s >= 3 * T1 && s <= 4 * T1) a -= poly(4 * T1 - s);
      return a;
    endfunction

    function bit seen(logic [23:0] d);
      return d > win_lo && d < win_hi;
    endfunction

    function void note_input(logic [71:0] d);
      longint t, a;
      logic [63:0] mag;
      phase_e ph;
      bit neg;
      t  = longint'(d[23:0]);
      a  = 0;
      ph = PH_NONE;
      if (t < 2 * T1 && seen(d[47:24])) begin
        ph = PH_PICK;
        a  = pick_sum(t);
      end else if (t >= 2 * T1 && t < 6 * T1 && seen(d[71:48])) begin
        ph = PH_PLACE;
        a  = place_sum(t - 2 * T1);
      end else if (t >= 6 * T1 && t < 8 * T1) begin
        ph = PH_RETURN;
        a  = pick_sum(t - 6 * T1);
      end
      neg = a < 0;
      mag = neg ? -a : a;
      mag = (mag * 64'd47523465 + 64'd4000000000) / 64'd8000000000;
      if (neg) begin
        if (mag > 64'd16777216) mag = 64'd16777216;
        mag = -mag;
      end else if (mag > 64'd16777215) begin
        mag = 64'd16777215;
      end
      exp_torque.push_back(mag[24:0]);
      exp_phase.push_back(ph);
    endfunction

    function void check_result(logic [31:0] d, logic [1:0] u);
      logic [24:0] et;
      phase_e ep;
      if (exp_torque.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result torque %h phase %0d", d[24:0], u);
        return;
      end
      et = exp_torque.pop_front();
      ep = exp_phase.pop_front();
      if (d[24:0] !== et || u !== ep || d[31:25] !== 7'd0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp torque %h phase %0d, got torque %h phase %0d pad %h",
                   et, ep, d[24:0], u, d[31:25]);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  torque_board board = new();
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;

  pick_place_torque_profile dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(int unsigned idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
    if (idx == REG_WINDOW_LOW) board.win_lo = val[23:0];
    else board.win_hi = val[23:0];
  endtask

  task automatic send(logic [23:0] t, logic [23:0] od, logic [23:0] gd);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {gd, od, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_input({gd, od, t});
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.exp_torque.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [23:0] near_window(bit hit);
    if (hit && board.win_hi > board.win_lo + 1)
      return 24'($urandom_range(board.win_hi - 1, board.win_lo + 1));
    case ($urandom_range(3))
      0: return board.win_lo;
      1: return board.win_hi;
      2: return 24'($urandom_range(16777215));
      default: return 24'(board.win_lo + $urandom_range(2));
    endcase
  endfunction

  task automatic random_run(int n);
    logic [23:0] t, od, gd;
    repeat (n) begin
      t  = ($urandom_range(9) == 0) ? 24'($urandom_range(16777215))
                                    : 24'($urandom_range(32'(8 * T1 + 99)));
      if ($urandom_range(19) == 0) t = 24'($urandom_range(8) * T1 + $urandom_range(2) - 1);
      od = near_window($urandom_range(3) != 0);
      gd = near_window($urandom_range(3) != 0);
      send(t, od, gd);
    end
  endtask

  initial begin
    logic [23:0] lo, hi;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    lo = 24'(WINDOW_LOW_RST + 10);
    // directed: boundaries, each phase, misses, overflow of time
    send(24'(0), lo, 24'(0));
    send(24'(T1 / 2), lo, 24'(0));
    send(24'(T1), lo, 24'(0));
    send(24'(3 * T1 / 2), lo, lo);
    send(24'(2 * T1 - 1), lo, 24'(0));
    send(24'(T1), 24'(0), lo);
    send(24'(2 * T1), 24'(0), lo);
    send(24'(3 * T1), 24'(0), lo);
    send(24'(4 * T1), 24'(0), lo);
    send(24'(5 * T1), 24'(0), lo);
    send(24'(11 * T1 / 2), 24'(0), lo);
    send(24'(6 * T1 - 1), lo, lo);
    send(24'(3 * T1), lo, 24'hFFFFFF);
    send(24'(6 * T1), 24'(0), 24'(0));
    send(24'(7 * T1), 24'(0), 24'(0));
    send(24'(15 * T1 / 2), 24'(0), 24'(0));
    send(24'(8 * T1 - 1), 24'(0), 24'(0));
    send(24'(8 * T1), lo, lo);
    send(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(24'(T1 / 3), WINDOW_LOW_RST, WINDOW_HIGH_RST);
    send(24'(T1 / 3), 24'(WINDOW_HIGH_RST - 1), 24'(0));
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin lo = '0; hi = 24'hFFFFFF; end
        2: begin lo = 24'hFFFFFF; hi = '0; end
        3: begin lo = 24'h555555; hi = 24'hAAAAAA; end
        4: begin lo = 24'hAAAAAA; hi = 24'hAAAAAA; end
        default: begin lo = WINDOW_LOW_RST; hi = WINDOW_HIGH_RST; end
      endcase
      if (ph > 0) begin
        write_reg(REG_WINDOW_LOW, {8'hFF, lo});
        write_reg(REG_WINDOW_HIGH, {8'hFF, hi});
      end
      for (int id = 0; id < 5; id++) begin
        send_idle  = (id == 1 || id == 4) ? 65 : ((id == 3) ? 25 : 0);
        recv_stall = (id == 2 || id == 4) ? 65 : ((id == 3) ? 25 : 0);
        random_run(33);
      end
      drain();
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
